// ===== src/bsc_pkg.sv =====
// ----------------------------------------------------------------------------
// bsc_pkg
// Shared types and constants of the barometric sensor compensation block.
// ----------------------------------------------------------------------------
package bsc_pkg;

    // configuration register indexes
    typedef enum logic [2:0] {
        REG_C1 = 3'd0,
        REG_C2 = 3'd1,
        REG_C3 = 3'd2,
        REG_C4 = 3'd3,
        REG_C5 = 3'd4,
        REG_C6 = 3'd5
    } reg_idx_t;

    typedef struct packed {
        logic [15:0] c1;
        logic [15:0] c2;
        logic [15:0] c3;
        logic [15:0] c4;
        logic [15:0] c5;
        logic [15:0] c6;
    } coef_t;

    // temperature thresholds in hundredths of a degree
    localparam logic signed [20:0] T_REF_CENTI = 21'sd2000;
    localparam logic signed [20:0] T_LOW_CENTI = -21'sd1500;

    // second-order offset factors
    localparam logic signed [6:0] OFF2_LOW_FACTOR  = 7'sd61;
    localparam logic signed [4:0] OFF2_XLOW_FACTOR = 5'sd15;

    // coefficient patterns flagged by the init check
    localparam logic [15:0] COEF_ZERO = 16'h0000;
    localparam logic [15:0] COEF_FF   = 16'h00FF;

    // pressure saturation bounds
    localparam logic signed [31:0] P_MAX = 32'sh7FFFFFFF;
    localparam logic signed [31:0] P_MIN = 32'sh80000000;

endpackage

// ===== src/bsc_coeff_regs.sv =====
// ----------------------------------------------------------------------------
// bsc_coeff_regs
// Calibration coefficient registers with write decode and init check flag.
// ----------------------------------------------------------------------------
module bsc_coeff_regs (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 cfg_valid,
    output logic                 cfg_ready,
    input  logic [2:0]           cfg_index,
    input  logic [15:0]          cfg_data,
    output bsc_pkg::coef_t       coef,
    output logic                 coef_bad
);

    bsc_pkg::coef_t coef_reg;
    bsc_pkg::coef_t coef_next;

    assign cfg_ready = 1'b1;

    always_comb
    begin
        coef_next = coef_reg;
        if (cfg_valid && cfg_ready)
        begin
            unique case (bsc_pkg::reg_idx_t'(cfg_index))
                bsc_pkg::REG_C1: coef_next.c1 = cfg_data;
                bsc_pkg::REG_C2: coef_next.c2 = cfg_data;
                bsc_pkg::REG_C3: coef_next.c3 = cfg_data;
                bsc_pkg::REG_C4: coef_next.c4 = cfg_data;
                bsc_pkg::REG_C5: coef_next.c5 = cfg_data;
                bsc_pkg::REG_C6: coef_next.c6 = cfg_data;
                default:         coef_next = coef_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            coef_reg <= '0;
        end
        else
        begin
            coef_reg <= coef_next;
        end
    end

    assign coef = coef_reg;

    // whole 16-bit word compared
    assign coef_bad =
        (coef_reg.c1 == bsc_pkg::COEF_ZERO) || (coef_reg.c1 == bsc_pkg::COEF_FF) ||
        (coef_reg.c2 == bsc_pkg::COEF_ZERO) || (coef_reg.c2 == bsc_pkg::COEF_FF) ||
        (coef_reg.c3 == bsc_pkg::COEF_ZERO) || (coef_reg.c3 == bsc_pkg::COEF_FF) ||
        (coef_reg.c4 == bsc_pkg::COEF_ZERO) || (coef_reg.c4 == bsc_pkg::COEF_FF) ||
        (coef_reg.c5 == bsc_pkg::COEF_ZERO) || (coef_reg.c5 == bsc_pkg::COEF_FF) ||
        (coef_reg.c6 == bsc_pkg::COEF_ZERO) || (coef_reg.c6 == bsc_pkg::COEF_FF);

endmodule

// ===== src/baro_sensor_compensation.sv =====
// ----------------------------------------------------------------------------
// baro_sensor_compensation
// Second-order temperature compensation of raw barometric sensor conversions.
// ----------------------------------------------------------------------------
// One item (raw pressure and raw temperature) enters per cycle unless stalled
// and leaves through a ten-stage pipeline: temperature difference, coefficient
// products, first-order terms, squares, second-order terms, final offset and
// sensitivity, split pressure product, product sum, offset subtract, then
// scale and saturate. Each stage holds when the stage after it is full and
// stalled, so empty stages still take items while a finished result waits at
// the output. The user must write coefficients through the config port only
// while no item is in flight; the block itself does not enforce this.
module baro_sensor_compensation (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_stall,
    input  logic [23:0]         raw_pressure,
    input  logic [23:0]         raw_temperature,
    output logic                out_valid,
    input  logic                out_stall,
    output logic signed [19:0]  temperature_centi,
    output logic signed [31:0]  pressure_pa,
    output logic                coeff_invalid,
    input  logic                cfg_valid,
    output logic                cfg_ready,
    input  logic [2:0]          cfg_index,
    input  logic [15:0]         cfg_data
);

    bsc_pkg::coef_t coef;
    logic           coef_bad;

    bsc_coeff_regs u_coeff_regs (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .coef      (coef),
        .coef_bad  (coef_bad)
    );

    // valid bits and per-stage advance
    logic [10:1] v_reg;
    logic [10:1] en;

    always_comb
    begin
        en[10] = !v_reg[10] || !out_stall;
        for (int k = 9; k >= 1; k--)
        begin
            en[k] = !v_reg[k] || en[k+1];
        end
    end

    assign in_stall  = !en[1];
    assign out_valid = v_reg[10];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_reg <= '0;
        end
        else
        begin
            if (en[1])
            begin
                v_reg[1] <= in_valid;
            end
            for (int k = 2; k <= 10; k++)
            begin
                if (en[k])
                begin
                    v_reg[k] <= v_reg[k-1];
                end
            end
        end
    end

    // stage 1: temperature difference
    logic [23:0]        d1_s1_reg;
    logic signed [24:0] dt_s1_reg;
    logic signed [24:0] dt_next;

    assign dt_next = $signed({1'b0, raw_temperature}) - $signed({1'b0, coef.c5, 8'd0});

    always_ff @(posedge clk)
    begin
        if (en[1])
        begin
            d1_s1_reg <= raw_pressure;
            dt_s1_reg <= dt_next;
        end
    end

    // stage 2: coefficient products and square of dt
    logic [23:0]        d1_s2_reg;
    logic signed [41:0] p6_s2_reg;
    logic signed [41:0] p4_s2_reg;
    logic signed [41:0] p3_s2_reg;
    logic signed [49:0] sq_s2_reg;
    logic signed [41:0] p6_next;
    logic signed [41:0] p4_next;
    logic signed [41:0] p3_next;
    logic signed [49:0] sq_next;

    assign p6_next = $signed({1'b0, coef.c6}) * dt_s1_reg;
    assign p4_next = $signed({1'b0, coef.c4}) * dt_s1_reg;
    assign p3_next = $signed({1'b0, coef.c3}) * dt_s1_reg;
    assign sq_next = dt_s1_reg * dt_s1_reg;

    always_ff @(posedge clk)
    begin
        if (en[2])
        begin
            d1_s2_reg <= d1_s1_reg;
            p6_s2_reg <= p6_next;
            p4_s2_reg <= p4_next;
            p3_s2_reg <= p3_next;
            sq_s2_reg <= sq_next;
        end
    end

    // stage 3: first-order temperature, offset, sensitivity
    logic [23:0]        d1_s3_reg;
    logic signed [20:0] temp_s3_reg;
    logic signed [37:0] off1_s3_reg;
    logic signed [36:0] sens1_s3_reg;
    logic signed [20:0] t2_s3_reg;
    logic signed [41:0] p6_sh;
    logic signed [41:0] p4_sh;
    logic signed [41:0] p3_sh;
    logic signed [49:0] sq_sh;
    logic signed [20:0] temp_next;
    logic signed [37:0] off1_next;
    logic signed [36:0] sens1_next;

    assign p6_sh = p6_s2_reg >>> 23;
    assign p4_sh = p4_s2_reg >>> 6;
    assign p3_sh = p3_s2_reg >>> 7;
    assign sq_sh = sq_s2_reg >>> 31;

    assign temp_next  = bsc_pkg::T_REF_CENTI + 21'(p6_sh);
    assign off1_next  = 38'($signed({1'b0, coef.c2, 17'd0})) + 38'(p4_sh);
    assign sens1_next = 37'($signed({1'b0, coef.c1, 16'd0})) + 37'(p3_sh);

    always_ff @(posedge clk)
    begin
        if (en[3])
        begin
            d1_s3_reg    <= d1_s2_reg;
            temp_s3_reg  <= temp_next;
            off1_s3_reg  <= off1_next;
            sens1_s3_reg <= sens1_next;
            t2_s3_reg    <= 21'(sq_sh);
        end
    end

    // stage 4: range flags, squares, second-order temperature
    logic [23:0]        d1_s4_reg;
    logic signed [20:0] temp_s4_reg;
    logic signed [37:0] off1_s4_reg;
    logic signed [36:0] sens1_s4_reg;
    logic signed [41:0] aa_s4_reg;
    logic signed [41:0] bb_s4_reg;
    logic               low_s4_reg;
    logic               xlow_s4_reg;
    logic signed [20:0] a_val;
    logic signed [20:0] b_val;
    logic               low_next;
    logic               xlow_next;
    logic signed [41:0] aa_next;
    logic signed [41:0] bb_next;
    logic signed [20:0] temp2_next;

    assign a_val     = temp_s3_reg - bsc_pkg::T_REF_CENTI;
    assign b_val     = temp_s3_reg - bsc_pkg::T_LOW_CENTI;
    assign low_next  = temp_s3_reg < bsc_pkg::T_REF_CENTI;
    assign xlow_next = temp_s3_reg < bsc_pkg::T_LOW_CENTI;
    assign aa_next   = a_val * a_val;
    assign bb_next   = b_val * b_val;
    assign temp2_next = low_next ? (temp_s3_reg - t2_s3_reg) : temp_s3_reg;

    always_ff @(posedge clk)
    begin
        if (en[4])
        begin
            d1_s4_reg    <= d1_s3_reg;
            temp_s4_reg  <= temp2_next;
            off1_s4_reg  <= off1_s3_reg;
            sens1_s4_reg <= sens1_s3_reg;
            aa_s4_reg    <= aa_next;
            bb_s4_reg    <= bb_next;
            low_s4_reg   <= low_next;
            xlow_s4_reg  <= xlow_next;
        end
    end

    // stage 5: second-order offset and sensitivity terms
    logic [23:0]        d1_s5_reg;
    logic signed [20:0] temp_s5_reg;
    logic signed [37:0] off1_s5_reg;
    logic signed [36:0] sens1_s5_reg;
    logic signed [47:0] off2_s5_reg;
    logic signed [45:0] sens2_s5_reg;
    logic signed [47:0] aa61;
    logic signed [47:0] aa61_sh;
    logic signed [47:0] bb15;
    logic signed [47:0] off2_next;
    logic signed [45:0] sens2_next;

    assign aa61    = aa_s4_reg * bsc_pkg::OFF2_LOW_FACTOR;
    assign aa61_sh = aa61 >>> 4;
    assign bb15    = bb_s4_reg * bsc_pkg::OFF2_XLOW_FACTOR;

    always_comb
    begin
        off2_next  = '0;
        sens2_next = '0;
        if (low_s4_reg)
        begin
            off2_next  = aa61_sh;
            sens2_next = 46'(aa_s4_reg) <<< 1;
            if (xlow_s4_reg)
            begin
                off2_next  = aa61_sh + bb15;
                sens2_next = (46'(aa_s4_reg) <<< 1) + (46'(bb_s4_reg) <<< 3);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (en[5])
        begin
            d1_s5_reg    <= d1_s4_reg;
            temp_s5_reg  <= temp_s4_reg;
            off1_s5_reg  <= off1_s4_reg;
            sens1_s5_reg <= sens1_s4_reg;
            off2_s5_reg  <= off2_next;
            sens2_s5_reg <= sens2_next;
        end
    end

    // stage 6: final offset and sensitivity
    logic [23:0]        d1_s6_reg;
    logic signed [20:0] temp_s6_reg;
    logic signed [48:0] off_s6_reg;
    logic signed [47:0] sens_s6_reg;

    always_ff @(posedge clk)
    begin
        if (en[6])
        begin
            d1_s6_reg   <= d1_s5_reg;
            temp_s6_reg <= temp_s5_reg;
            off_s6_reg  <= 49'(off1_s5_reg) - 49'(off2_s5_reg);
            sens_s6_reg <= 48'(sens1_s5_reg) - 48'(sens2_s5_reg);
        end
    end

    // stage 7: pressure product split in two halves of sens
    logic signed [20:0] temp_s7_reg;
    logic signed [48:0] off_s7_reg;
    logic signed [48:0] pp_hi_s7_reg;
    logic signed [49:0] pp_lo_s7_reg;
    logic signed [24:0] d1_sg;
    logic signed [23:0] sens_hi;
    logic signed [24:0] sens_lo;
    logic signed [48:0] pp_hi_next;
    logic signed [49:0] pp_lo_next;

    assign d1_sg      = $signed({1'b0, d1_s6_reg});
    assign sens_hi    = sens_s6_reg[47:24];
    assign sens_lo    = $signed({1'b0, sens_s6_reg[23:0]});
    assign pp_hi_next = d1_sg * sens_hi;
    assign pp_lo_next = d1_sg * sens_lo;

    always_ff @(posedge clk)
    begin
        if (en[7])
        begin
            temp_s7_reg  <= temp_s6_reg;
            off_s7_reg   <= off_s6_reg;
            pp_hi_s7_reg <= pp_hi_next;
            pp_lo_s7_reg <= pp_lo_next;
        end
    end

    // stage 8: recombine product
    logic signed [20:0] temp_s8_reg;
    logic signed [48:0] off_s8_reg;
    logic signed [73:0] prod_s8_reg;

    always_ff @(posedge clk)
    begin
        if (en[8])
        begin
            temp_s8_reg <= temp_s7_reg;
            off_s8_reg  <= off_s7_reg;
            prod_s8_reg <= (74'(pp_hi_s7_reg) <<< 24) + 74'(pp_lo_s7_reg);
        end
    end

    // stage 9: scale product and remove offset
    logic signed [20:0] temp_s9_reg;
    logic signed [53:0] x_s9_reg;
    logic signed [73:0] prod_sh;

    assign prod_sh = prod_s8_reg >>> 21;

    always_ff @(posedge clk)
    begin
        if (en[9])
        begin
            temp_s9_reg <= temp_s8_reg;
            x_s9_reg    <= 54'(prod_sh) - 54'(off_s8_reg);
        end
    end

    // stage 10: final scale, saturate, output register
    logic signed [19:0] temp_out_reg;
    logic signed [31:0] p_out_reg;
    logic               bad_out_reg;
    logic signed [53:0] p_sh;
    logic signed [31:0] p_sat;

    assign p_sh = x_s9_reg >>> 15;

    always_comb
    begin
        if (p_sh > 54'(bsc_pkg::P_MAX))
        begin
            p_sat = bsc_pkg::P_MAX;
        end
        else if (p_sh < 54'(bsc_pkg::P_MIN))
        begin
            p_sat = bsc_pkg::P_MIN;
        end
        else
        begin
            p_sat = p_sh[31:0];
        end
    end

    always_ff @(posedge clk)
    begin
        if (en[10])
        begin
            temp_out_reg <= temp_s9_reg[19:0];
            p_out_reg    <= p_sat;
            bad_out_reg  <= coef_bad;
        end
    end

    assign temperature_centi = temp_out_reg;
    assign pressure_pa       = p_out_reg;
    assign coeff_invalid     = bad_out_reg;

    // input is held back only when every stage is full behind a stalled output
    a_stall_only_when_full: assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> (out_valid && out_stall && (v_reg[9:1] == '1)))
        else $error("input stalled while the pipeline has room");

    // an item in stage 9 moves into an empty output register
    a_fill_output: assert property (@(posedge clk) disable iff (!rst_n)
        (v_reg[9] && !out_valid) |=> out_valid)
        else $error("item did not reach the empty output register");

    // an item behind a stalled output is kept
    a_hold_behind_stall: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && out_stall && v_reg[9]) |=> v_reg[9])
        else $error("item lost behind a stalled output");

endmodule

// ===== tb/sv/bsc_compensation_check.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bsc_compensation_check
// Watches the item, result and calibration channels of the compensation
// block, computes the compensated reading of every accepted item from its own
// copy of the calibration words and compares each result field by field.
// ----------------------------------------------------------------------------
module bsc_compensation_check (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    input  logic               in_stall,
    input  logic [23:0]        raw_pressure,
    input  logic [23:0]        raw_temperature,
    input  logic               out_valid,
    input  logic               out_stall,
    input  logic signed [19:0] temperature_centi,
    input  logic signed [31:0] pressure_pa,
    input  logic               coeff_invalid,
    input  logic               cfg_valid,
    input  logic               cfg_ready,
    input  logic [2:0]         cfg_index,
    input  logic [15:0]        cfg_data,
    output int                 fail_count,
    output int                 outstanding
);

    typedef struct {
        logic signed [19:0] temp;
        logic signed [31:0] pres;
        logic               bad;
    } reading_t;

    localparam int PRINT_CAP = 100;

    bsc_pkg::coef_t held_coefs;
    reading_t       expected_readings[$];
    reading_t       want;
    int             results_seen;

    initial fail_count = 0;

    // first-order terms, then the cold corrections, all in 64-bit signed
    function automatic reading_t compensate(input bsc_pkg::coef_t k,
                                            input logic [23:0] d1_raw,
                                            input logic [23:0] d2_raw);
        longint d1, d2, c1, c2, c3, c4, c5, c6;
        longint dt, temp, off, sens, t2, off2, sens2, a, b, p;
        logic [15:0] words [0:5];
        reading_t r;
        d1 = d1_raw;
        d2 = d2_raw;
        c1 = k.c1;
        c2 = k.c2;
        c3 = k.c3;
        c4 = k.c4;
        c5 = k.c5;
        c6 = k.c6;
        dt = d2 - (c5 << 8);
        temp = longint'(bsc_pkg::T_REF_CENTI) + ((c6 * dt) >>> 23);
        off = (c2 << 17) + ((c4 * dt) >>> 6);
        sens = (c1 << 16) + ((c3 * dt) >>> 7);
        t2 = 0;
        off2 = 0;
        sens2 = 0;
        if (temp < longint'(bsc_pkg::T_REF_CENTI))
        begin
            a = temp - longint'(bsc_pkg::T_REF_CENTI);
            t2 = (dt * dt) >>> 31;
            off2 = (longint'(bsc_pkg::OFF2_LOW_FACTOR) * a * a) >>> 4;
            sens2 = 2 * a * a;
            if (temp < longint'(bsc_pkg::T_LOW_CENTI))
            begin
                b = temp - longint'(bsc_pkg::T_LOW_CENTI);
                off2 += longint'(bsc_pkg::OFF2_XLOW_FACTOR) * b * b;
                sens2 += 8 * b * b;
            end
        end
        temp -= t2;
        off -= off2;
        sens -= sens2;
        p = (((d1 * sens) >>> 21) - off) >>> 15;
        if (p > longint'(bsc_pkg::P_MAX))
            p = longint'(bsc_pkg::P_MAX);
        if (p < longint'(bsc_pkg::P_MIN))
            p = longint'(bsc_pkg::P_MIN);
        words = '{k.c1, k.c2, k.c3, k.c4, k.c5, k.c6};
        r.bad = 1'b0;
        foreach (words[i])
            if (words[i] == bsc_pkg::COEF_ZERO || words[i] == bsc_pkg::COEF_FF)
                r.bad = 1'b1;
        r.temp = temp[19:0];
        r.pres = p[31:0];
        return r;
    endfunction

    task automatic report_mismatch(input string what, input longint got, input longint exp_val);
        if (fail_count < PRINT_CAP)
            $display("mismatch on result %0d: %s got %0d expected %0d",
                     results_seen, what, got, exp_val);
        fail_count++;
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            held_coefs = '0;
            expected_readings.delete();
            results_seen = 0;
            outstanding <= 0;
        end
        else
        begin
            if (cfg_valid && cfg_ready)
            begin
                case (cfg_index)
                    bsc_pkg::REG_C1: held_coefs.c1 = cfg_data;
                    bsc_pkg::REG_C2: held_coefs.c2 = cfg_data;
                    bsc_pkg::REG_C3: held_coefs.c3 = cfg_data;
                    bsc_pkg::REG_C4: held_coefs.c4 = cfg_data;
                    bsc_pkg::REG_C5: held_coefs.c5 = cfg_data;
                    bsc_pkg::REG_C6: held_coefs.c6 = cfg_data;
                    default: ; // spare indexes leave the words alone
                endcase
            end
            if (in_valid && !in_stall)
                expected_readings.push_back(compensate(held_coefs, raw_pressure,
                                                       raw_temperature));
            if (out_valid && !out_stall)
            begin
                if (expected_readings.size() == 0)
                    report_mismatch("result with no item pending", 0, 0);
                else
                begin
                    want = expected_readings.pop_front();
                    if (temperature_centi !== want.temp)
                        report_mismatch("temperature_centi", temperature_centi, want.temp);
                    if (pressure_pa !== want.pres)
                        report_mismatch("pressure_pa", pressure_pa, want.pres);
                    if (coeff_invalid !== want.bad)
                        report_mismatch("coeff_invalid", coeff_invalid, want.bad);
                end
                results_seen++;
            end
            outstanding <= expected_readings.size();
        end
    end

endmodule

// ===== tb/sv/tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Drives the compensation block through several calibration settings: a
// directed set of corner items, then shaped random conversions around the
// reference temperature, with random idling on both channels but in one burst.
// ----------------------------------------------------------------------------
module tb;

    localparam int          RAW_MAX        = 24'hFFFFFF;
    localparam int          WATCHDOG_LIMIT = 2000;
    localparam int          TAIL_CYCLES    = 20;
    localparam int          RANDOM_ITEMS   = 225;
    localparam logic [2:0]  REG_SPARE_A    = 3'd6;
    localparam logic [2:0]  REG_SPARE_B    = 3'd7;

    logic               clk = 1'b0;
    logic               rst_n = 1'b0;
    logic               in_valid = 1'b0;
    logic               in_stall;
    logic [23:0]        raw_pressure = '0;
    logic [23:0]        raw_temperature = '0;
    logic               out_valid;
    logic               out_stall = 1'b0;
    logic signed [19:0] temperature_centi;
    logic signed [31:0] pressure_pa;
    logic               coeff_invalid;
    logic               cfg_valid = 1'b0;
    logic               cfg_ready;
    logic [2:0]         cfg_index = bsc_pkg::REG_C1;
    logic [15:0]        cfg_data = '0;

    logic               burst = 1'b0;
    int                 fail_count;
    int                 outstanding;
    int                 idle_cycles = 0;

    bsc_pkg::coef_t     typical_coefs;
    bsc_pkg::coef_t     coefs;

    always #4 clk = ~clk;

    baro_sensor_compensation dut (
        .clk               (clk),
        .rst_n             (rst_n),
        .in_valid          (in_valid),
        .in_stall          (in_stall),
        .raw_pressure      (raw_pressure),
        .raw_temperature   (raw_temperature),
        .out_valid         (out_valid),
        .out_stall         (out_stall),
        .temperature_centi (temperature_centi),
        .pressure_pa       (pressure_pa),
        .coeff_invalid     (coeff_invalid),
        .cfg_valid         (cfg_valid),
        .cfg_ready         (cfg_ready),
        .cfg_index         (cfg_index),
        .cfg_data          (cfg_data)
    );

    bsc_compensation_check checker_i (
        .clk               (clk),
        .rst_n             (rst_n),
        .in_valid          (in_valid),
        .in_stall          (in_stall),
        .raw_pressure      (raw_pressure),
        .raw_temperature   (raw_temperature),
        .out_valid         (out_valid),
        .out_stall         (out_stall),
        .temperature_centi (temperature_centi),
        .pressure_pa       (pressure_pa),
        .coeff_invalid     (coeff_invalid),
        .cfg_valid         (cfg_valid),
        .cfg_ready         (cfg_ready),
        .cfg_index         (cfg_index),
        .cfg_data          (cfg_data),
        .fail_count        (fail_count),
        .outstanding       (outstanding)
    );

    // result side back-pressure
    always @(posedge clk)
        out_stall <= !burst && ($urandom_range(0, 99) < 23);

    always @(posedge clk)
    begin
        if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall)
            || (cfg_valid && cfg_ready))
            idle_cycles <= 0;
        else if (idle_cycles == WATCHDOG_LIMIT)
        begin
            $display("FAIL baro_sensor_compensation");
            $finish;
        end
        else
            idle_cycles <= idle_cycles + 1;
    end

    task automatic send_item(input logic [23:0] d1, input logic [23:0] d2);
        while (!burst && $urandom_range(0, 99) < 23)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid        <= 1'b1;
        raw_pressure    <= d1;
        raw_temperature <= d2;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
    endtask

    task automatic drain_results();
        in_valid <= 1'b0;
        do
            @(posedge clk);
        while (outstanding != 0);
    endtask

    task automatic write_reg(input logic [2:0] idx, input logic [15:0] val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
    endtask

    task automatic write_coefs(input bsc_pkg::coef_t k, input bit with_spares);
        write_reg(bsc_pkg::REG_C1, k.c1);
        write_reg(bsc_pkg::REG_C2, k.c2);
        write_reg(bsc_pkg::REG_C3, k.c3);
        write_reg(bsc_pkg::REG_C4, k.c4);
        write_reg(bsc_pkg::REG_C5, k.c5);
        write_reg(bsc_pkg::REG_C6, k.c6);
        // spare indexes after the real words so any aliasing shows up
        if (with_spares)
        begin
            write_reg(REG_SPARE_A, 16'($urandom));
            write_reg(REG_SPARE_B, 16'($urandom));
        end
        cfg_valid <= 1'b0;
    endtask

    function automatic logic [23:0] pick_pressure_raw();
        if ($urandom_range(0, 7) == 0)
            return $urandom_range(0, 1) ? RAW_MAX[23:0] : 24'd0;
        return 24'($urandom_range(0, RAW_MAX));
    endfunction

    // most temperatures land near or below the reference so the cold paths run
    function automatic logic [23:0] pick_temp_raw(input logic [15:0] c5);
        int centre;
        int v;
        centre = c5;
        centre = centre << 8;
        case ($urandom_range(0, 9))
            0, 1, 2: v = $urandom_range(0, RAW_MAX);
            3, 4, 5: v = centre + int'($urandom_range(0, 1 << 21)) - (1 << 20);
            6, 7, 8: v = centre - int'($urandom_range(0, 1 << 22));
            default: v = $urandom_range(0, 1) ? RAW_MAX : 0;
        endcase
        if (v < 0)
            v = 0;
        if (v > RAW_MAX)
            v = RAW_MAX;
        return v[23:0];
    endfunction

    task automatic run_random(input bsc_pkg::coef_t k, input int count, input bit mid_pause);
        for (int i = 0; i < count; i++)
        begin
            if (mid_pause && i == count / 2)
                drain_results();
            send_item(pick_pressure_raw(), pick_temp_raw(k.c5));
        end
        drain_results();
    endtask

    task automatic run_directed(input bsc_pkg::coef_t k);
        longint ref_raw;
        longint cold_dt;
        logic [23:0] mid;
        ref_raw = longint'(k.c5) << 8;
        // raw offset at which the first-order temperature crosses the cold limit
        cold_dt = -((longint'(bsc_pkg::T_REF_CENTI - bsc_pkg::T_LOW_CENTI) << 23)
                    / longint'(k.c6));
        mid = 24'h62A5E4;
        send_item(24'd0, 24'd0);
        send_item(RAW_MAX[23:0], RAW_MAX[23:0]);
        send_item(24'd0, RAW_MAX[23:0]);
        send_item(RAW_MAX[23:0], 24'd0);
        send_item(mid, 24'(ref_raw));
        send_item(RAW_MAX[23:0], 24'(ref_raw - 1));
        send_item(24'd0, 24'(ref_raw + 1));
        send_item(mid, 24'(ref_raw - 300000));
        send_item(RAW_MAX[23:0], 24'(ref_raw - 300000));
        send_item(mid, 24'(ref_raw + cold_dt + 1));
        send_item(mid, 24'(ref_raw + cold_dt));
        send_item(mid, 24'(ref_raw + cold_dt - 1));
        send_item(RAW_MAX[23:0], 24'(ref_raw - 2000000));
        send_item(24'd0, 24'(ref_raw - 2000000));
        send_item(mid, 24'(ref_raw + 2000000));
        send_item(24'h000001, 24'h800000);
        drain_results();
    endtask

    function automatic bsc_pkg::coef_t random_coefs();
        bsc_pkg::coef_t k;
        k.c1 = 16'($urandom);
        k.c2 = 16'($urandom);
        k.c3 = 16'($urandom);
        k.c4 = 16'($urandom);
        k.c5 = 16'($urandom);
        k.c6 = 16'($urandom);
        return k;
    endfunction

    initial
    begin
        typical_coefs = '{c1: 16'd46372, c2: 16'd43981, c3: 16'd29059,
                          c4: 16'd27842, c5: 16'd31553, c6: 16'd28165};
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        write_coefs(typical_coefs, 1'b0);
        run_directed(typical_coefs);
        run_random(typical_coefs, RANDOM_ITEMS, 1'b1);

        // top of the calibration range, back to back with no idling
        coefs = '{c1: 16'hFFFF, c2: 16'hFFFF, c3: 16'hFFFF,
                  c4: 16'hFFFF, c5: 16'hFFFF, c6: 16'hFFFF};
        burst <= 1'b1;
        write_coefs(coefs, 1'b0);
        run_random(coefs, RANDOM_ITEMS, 1'b0);
        burst <= 1'b0;

        coefs = '0;
        write_coefs(coefs, 1'b1);
        run_random(coefs, RANDOM_ITEMS / 2, 1'b0);

        // a single word hitting the erased-byte pattern
        coefs = typical_coefs;
        case ($urandom_range(0, 5))
            0: coefs.c1 = bsc_pkg::COEF_FF;
            1: coefs.c2 = bsc_pkg::COEF_FF;
            2: coefs.c3 = bsc_pkg::COEF_FF;
            3: coefs.c4 = bsc_pkg::COEF_FF;
            4: coefs.c5 = bsc_pkg::COEF_FF;
            default: coefs.c6 = bsc_pkg::COEF_FF;
        endcase
        write_coefs(coefs, 1'b1);
        run_random(coefs, RANDOM_ITEMS, 1'b0);

        coefs = random_coefs();
        write_coefs(coefs, 1'b0);
        run_random(coefs, RANDOM_ITEMS, 1'b1);

        coefs = random_coefs();
        write_coefs(coefs, 1'b0);
        run_random(coefs, RANDOM_ITEMS, 1'b0);

        repeat (TAIL_CYCLES) @(posedge clk);
        if (fail_count == 0 && outstanding == 0)
            $display("PASS baro_sensor_compensation");
        else
            $display("FAIL baro_sensor_compensation");
        $finish;
    end

endmodule

// ===== files.f =====
src/bsc_pkg.sv
src/bsc_coeff_regs.sv
src/baro_sensor_compensation.sv
tb/sv/bsc_compensation_check.sv
tb/sv/tb.sv
